@@ design/tfn_pkg.sv @@
package tfn_pkg;

  // Vertex store
  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int IDX_W        = 10;

  // Datapath widths
  localparam int COORD_W  = 16;             // Q8.8 coordinate
  localparam int DIFF_W   = COORD_W + 1;    // edge vector component
  localparam int PROD_W   = 2 * DIFF_W;     // one partial product of the cross product
  localparam int WIDE_W   = PROD_W + 1;     // difference of two partial products
  localparam int MAG_W    = PROD_W;         // cross product magnitude
  localparam int NORM_W   = 30;             // magnitude after the normalizing shift
  localparam int SQ_W     = 2 * NORM_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int QUO_W    = 15;
  localparam int NORMAL_W = 16;             // Q1.14 result

  localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(1) << (QUO_W - 1);

  // Input item opcodes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_NORMAL = 1'b1;

  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [NORMAL_W-1:0] normal_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  // Cross product as sign and magnitude per component
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } cross_t;

  // Normalized magnitudes and their Euclidean length
  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][NORM_W-1:0] mag;
    logic [ROOT_W-1:0]      len;
  } root_t;

  typedef struct packed {
    normal_t normal_x;
    normal_t normal_y;
    normal_t normal_z;
    logic    degenerate;
  } result_t;

  function automatic logic in_range(input idx_t idx);
    return 32'(idx) < 32'(VERTEX_DEPTH);
  endfunction

endpackage

@@ design/tfn_if.sv @@
interface tfn_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  tfn_pkg::idx_t   vertex_index;
  tfn_pkg::coord_t pos_x;
  tfn_pkg::coord_t pos_y;
  tfn_pkg::coord_t pos_z;
  tfn_pkg::idx_t   corner_a;
  tfn_pkg::idx_t   corner_b;
  tfn_pkg::idx_t   corner_c;

  modport source (
    output valid, mode, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, mode, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

interface tfn_out_if;
  logic             valid;
  logic             ready;
  tfn_pkg::normal_t normal_x;
  tfn_pkg::normal_t normal_y;
  tfn_pkg::normal_t normal_z;
  logic             degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

@@ design/triangle_face_normal_core.sv @@
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   mode, vertex_index, pos_x/y/z, corner_a/b/c
// out_o     out  valid/ready   normal_x/y/z (Q1.14), degenerate
//
// A vertex write is taken while the block is idle and yields no transaction on out_o.
// A face normal passes the cross product, s = 0..29 normalizing shifts, the squares, the
// root, the handoff, the divide and the output register before out_o.valid rises; a
// degenerate triangle skips from the shift to the divider's hold. in_i then reopens.
// Reset clears all control state; the vertex store holds garbage until written.
// A stalled out_o holds the next normal in the divider and closes in_i until it drains.
module triangle_face_normal_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfn_in_if.sink    in_i,
  tfn_out_if.source out_o
);

  logic             busy_q;
  logic             accept;
  logic             wr_en;
  logic             start;
  tfn_pkg::vertex_t wdata;
  tfn_pkg::addr_t   raddr;
  tfn_pkg::vertex_t rdata;
  logic             cross_done;
  tfn_pkg::cross_t  cross_res;
  logic             root_done;
  tfn_pkg::root_t   root_res;
  logic             div_valid;
  logic             div_take;
  tfn_pkg::result_t div_res;
  logic             out_valid_q;
  tfn_pkg::result_t out_q;

  // one face normal in flight at a time; vertex writes only while idle
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && (in_i.mode == tfn_pkg::MODE_NORMAL);
  assign wr_en      = accept && (in_i.mode == tfn_pkg::MODE_WRITE)
                    && tfn_pkg::in_range(in_i.vertex_index);

  always_comb begin
    wdata.x = in_i.pos_x;
    wdata.y = in_i.pos_y;
    wdata.z = in_i.pos_z;
  end

  tfn_ram #(
    .DEPTH (tfn_pkg::VERTEX_DEPTH),
    .WIDTH ($bits(tfn_pkg::vertex_t))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tfn_pkg::addr_t'(in_i.vertex_index)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fetch corners, edge vectors, cross product as sign and magnitude
  tfn_cross u_cross (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .corner_a_i (in_i.corner_a),
    .corner_b_i (in_i.corner_b),
    .corner_c_i (in_i.corner_c),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .done_o     (cross_done),
    .res_o      (cross_res)
  );

  // normalize to 30 bits, sum of squares, integer square root
  tfn_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cross_done),
    .res_i   (cross_res),
    .done_o  (root_done),
    .res_o   (root_res)
  );

  // scale each component by the length, rounded half up
  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_done),
    .res_i   (root_res),
    .valid_o (div_valid),
    .take_i  (div_take),
    .res_o   (div_res)
  );

  // advance the result into the output register when it is empty or draining
  assign div_take = div_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
      end else if (div_take) begin
        busy_q <= 1'b0;
      end
      if (div_take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      out_q <= div_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.normal_x   = out_q.normal_x;
  assign out_o.normal_y   = out_q.normal_y;
  assign out_o.normal_z   = out_q.normal_z;
  assign out_o.degenerate = out_q.degenerate;

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_take |-> busy_q)
    else $error("result handed over with no face normal in flight");

endmodule

@@ design/tfn_ram.sv @@
module tfn_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tfn_cross.sv @@
module tfn_cross (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tfn_pkg::idx_t    corner_a_i,
  input  tfn_pkg::idx_t    corner_b_i,
  input  tfn_pkg::idx_t    corner_c_i,
  output tfn_pkg::addr_t   raddr_o,
  input  tfn_pkg::vertex_t rdata_i,
  output logic             done_o,
  output tfn_pkg::cross_t  res_o
);

  localparam logic [3:0] STEP_SEND_A = 4'd0;
  localparam logic [3:0] STEP_GET_A  = 4'd1;
  localparam logic [3:0] STEP_GET_B  = 4'd2;
  localparam logic [3:0] STEP_GET_C  = 4'd3;
  localparam logic [3:0] STEP_M0     = 4'd4;
  localparam logic [3:0] STEP_M1     = 4'd5;
  localparam logic [3:0] STEP_M2     = 4'd6;
  localparam logic [3:0] STEP_M3     = 4'd7;
  localparam logic [3:0] STEP_M4     = 4'd8;
  localparam logic [3:0] STEP_M5     = 4'd9;
  localparam logic [3:0] STEP_LAST   = 4'd10;

  logic                  busy_q;
  logic                  done_q;
  logic [3:0]            cnt_q;
  tfn_pkg::idx_t         ia_q;
  tfn_pkg::idx_t         ib_q;
  tfn_pkg::idx_t         ic_q;
  tfn_pkg::idx_t         rd_idx;
  logic                  rng_q;
  tfn_pkg::vertex_t      vtx;
  tfn_pkg::vertex_t      pa_q;
  tfn_pkg::diff_t        a_q [3];
  tfn_pkg::diff_t        b_q [3];
  tfn_pkg::diff_t        op_x;
  tfn_pkg::diff_t        op_y;
  tfn_pkg::prod_t        prod_q;
  tfn_pkg::prod_t        acc_q;
  tfn_pkg::wide_t        d_pos;
  tfn_pkg::wide_t        d_neg;
  logic                  c_neg;
  logic [tfn_pkg::MAG_W-1:0] c_mag;
  tfn_pkg::cross_t       res_q;

  // read corners A, B, C on consecutive cycles
  always_comb begin
    case (cnt_q)
      STEP_SEND_A: rd_idx = ia_q;
      STEP_GET_A:  rd_idx = ib_q;
      default:     rd_idx = ic_q;
    endcase
  end

  assign raddr_o = tfn_pkg::addr_t'(rd_idx);
  assign vtx     = rng_q ? rdata_i : '0;

  // one shared multiplier walks the six partial products
  always_comb begin
    case (cnt_q)
      STEP_M0: begin op_x = b_q[1]; op_y = a_q[2]; end
      STEP_M1: begin op_x = b_q[2]; op_y = a_q[1]; end
      STEP_M2: begin op_x = b_q[2]; op_y = a_q[0]; end
      STEP_M3: begin op_x = b_q[0]; op_y = a_q[2]; end
      STEP_M4: begin op_x = b_q[0]; op_y = a_q[1]; end
      STEP_M5: begin op_x = b_q[1]; op_y = a_q[0]; end
      default: begin op_x = '0;     op_y = '0;     end
    endcase
  end

  assign d_pos = tfn_pkg::wide_t'(acc_q) - tfn_pkg::wide_t'(prod_q);
  assign d_neg = tfn_pkg::wide_t'(prod_q) - tfn_pkg::wide_t'(acc_q);
  assign c_neg = d_pos[tfn_pkg::WIDE_W-1];
  assign c_mag = c_neg ? d_neg[tfn_pkg::MAG_W-1:0] : d_pos[tfn_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == STEP_LAST) begin
          busy_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rng_q  <= tfn_pkg::in_range(rd_idx);
    prod_q <= tfn_pkg::prod_t'(op_x) * tfn_pkg::prod_t'(op_y);
    if (start_i) begin
      ia_q <= corner_a_i;
      ib_q <= corner_b_i;
      ic_q <= corner_c_i;
    end
    if (busy_q) begin
      case (cnt_q)
        STEP_GET_A: pa_q <= vtx;
        STEP_GET_B: begin
          a_q[0] <= tfn_pkg::diff_t'(vtx.x) - tfn_pkg::diff_t'(pa_q.x);
          a_q[1] <= tfn_pkg::diff_t'(vtx.y) - tfn_pkg::diff_t'(pa_q.y);
          a_q[2] <= tfn_pkg::diff_t'(vtx.z) - tfn_pkg::diff_t'(pa_q.z);
        end
        STEP_GET_C: begin
          b_q[0] <= tfn_pkg::diff_t'(vtx.x) - tfn_pkg::diff_t'(pa_q.x);
          b_q[1] <= tfn_pkg::diff_t'(vtx.y) - tfn_pkg::diff_t'(pa_q.y);
          b_q[2] <= tfn_pkg::diff_t'(vtx.z) - tfn_pkg::diff_t'(pa_q.z);
        end
        STEP_M1, STEP_M3, STEP_M5: acc_q <= prod_q;
        STEP_M2: begin
          res_q.neg[0] <= c_neg;
          res_q.mag[0] <= c_mag;
        end
        STEP_M4: begin
          res_q.neg[1] <= c_neg;
          res_q.mag[1] <= c_mag;
        end
        STEP_LAST: begin
          res_q.neg[2] <= c_neg;
          res_q.mag[2] <= c_mag;
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("cross product done held for more than one cycle");

endmodule

@@ design/tfn_root.sv @@
module tfn_root (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tfn_pkg::cross_t res_i,
  output logic            done_o,
  output tfn_pkg::root_t  res_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [4:0] SQ_LAST   = 5'd3;
  localparam logic [4:0] SQRT_LAST = 5'(tfn_pkg::ROOT_W - 1);

  logic [2:0]                       state_q;
  logic [4:0]                       cnt_q;
  logic [2:0][tfn_pkg::MAG_W-1:0]   mag_q;
  logic [2:0]                       neg_q;
  logic                             degen_q;
  logic [tfn_pkg::MAG_W-1:0]        orv;
  logic                             too_big;
  logic                             fit;
  logic [tfn_pkg::SQ_W-1:0]         sq_q;
  logic [tfn_pkg::SUM_W-1:0]        sum_q;
  logic [tfn_pkg::REM_W-1:0]        rem_q;
  logic [tfn_pkg::ROOT_W-1:0]       root_q;
  logic [tfn_pkg::REM_W+1:0]        rem_sh;
  logic [tfn_pkg::REM_W+1:0]        trial;

  // the OR of the magnitudes has the bit length of the largest one
  assign orv     = mag_q[0] | mag_q[1] | mag_q[2];
  assign too_big = |orv[tfn_pkg::MAG_W-1:tfn_pkg::NORM_W];
  assign fit     = orv[tfn_pkg::NORM_W-1] && !too_big;

  // digit-by-digit square root, two radicand bits per cycle
  assign rem_sh = {rem_q, sum_q[tfn_pkg::SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (orv == '0) begin
            state_q <= ST_DONE;
          end else if (fit) begin
            state_q <= ST_SQUARE;
            cnt_q   <= '0;
          end
        end
        ST_SQUARE: begin
          if (cnt_q == SQ_LAST) begin
            state_q <= ST_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SQRT: begin
          if (cnt_q == SQRT_LAST) begin
            state_q <= ST_DONE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mag_q   <= res_i.mag;
          neg_q   <= res_i.neg;
          degen_q <= 1'b0;
        end
      end
      ST_SHIFT: begin
        if (orv == '0) begin
          degen_q <= 1'b1;
        end else if (too_big) begin
          for (int k = 0; k < 3; k++) begin
            mag_q[k] <= mag_q[k] >> 1;
          end
        end else if (!fit) begin
          for (int k = 0; k < 3; k++) begin
            mag_q[k] <= mag_q[k] << 1;
          end
        end else begin
          sum_q <= '0;
        end
      end
      ST_SQUARE: begin
        // square the head, rotate; three rotations restore the order
        if (cnt_q != SQ_LAST) begin
          sq_q  <= tfn_pkg::SQ_W'(mag_q[0][tfn_pkg::NORM_W-1:0])
                 * tfn_pkg::SQ_W'(mag_q[0][tfn_pkg::NORM_W-1:0]);
          mag_q <= {mag_q[0], mag_q[2], mag_q[1]};
        end
        if (cnt_q != '0) begin
          sum_q <= sum_q + tfn_pkg::SUM_W'(sq_q);
        end
        if (cnt_q == SQ_LAST) begin
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        sum_q <= sum_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= tfn_pkg::REM_W'(rem_sh - trial);
          root_q <= {root_q[tfn_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[tfn_pkg::REM_W-1:0];
          root_q <= {root_q[tfn_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.degen = degen_q;
    res_o.neg   = neg_q;
    res_o.len   = root_q;
    for (int k = 0; k < 3; k++) begin
      res_o.mag[k] = mag_q[k][tfn_pkg::NORM_W-1:0];
    end
  end

  assign done_o = (state_q == ST_DONE);

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQUARE && cnt_q == '0) |-> fit)
    else $error("largest magnitude not normalized before squaring");

  a_len_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !degen_q) |-> (root_q[tfn_pkg::ROOT_W-1 -: 2] != 2'b00))
    else $error("length below the normalized largest magnitude");

endmodule

@@ design/tfn_div.sv @@
module tfn_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tfn_pkg::root_t   res_i,
  output logic             valid_o,
  input  logic             take_i,
  output tfn_pkg::result_t res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [3:0] CNT_LAST = 4'(tfn_pkg::QUO_W - 1);

  logic [1:0]                       state_q;
  logic [3:0]                       cnt_q;
  logic [tfn_pkg::DEN_W-1:0]        den_q;
  logic [tfn_pkg::QUO_W-1:0]        nlo_q;
  logic [2:0][tfn_pkg::REM_W-1:0]   rem_q;
  logic [2:0][tfn_pkg::REM_W-1:0]   rem_d;
  logic [2:0][tfn_pkg::QUO_W-1:0]   quo_q;
  logic [2:0][tfn_pkg::QUO_W-1:0]   quo_d;
  logic [2:0][tfn_pkg::REM_W:0]     rsh;
  logic [2:0]                       neg_q;
  logic                             degen_q;
  tfn_pkg::normal_t                 nrm [3];

  // three restoring-division lanes share the divisor and the numerator tail
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsh[k] = {rem_q[k], nlo_q[tfn_pkg::QUO_W-1]};
      if (rsh[k] >= {1'b0, den_q}) begin
        rem_d[k] = tfn_pkg::REM_W'(rsh[k] - {1'b0, den_q});
        quo_d[k] = {quo_q[k][tfn_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rsh[k][tfn_pkg::REM_W-1:0];
        quo_d[k] = {quo_q[k][tfn_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= res_i.degen ? ST_HOLD : ST_RUN;
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_HOLD;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_HOLD: begin
          if (take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // numerator is mag * 2^15 + len, divisor 2 * len: rounds half up
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      den_q   <= {res_i.len, 1'b0};
      nlo_q   <= res_i.len[tfn_pkg::QUO_W-1:0];
      neg_q   <= res_i.neg;
      degen_q <= res_i.degen;
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= tfn_pkg::REM_W'(res_i.mag[k])
                  + tfn_pkg::REM_W'(res_i.len[tfn_pkg::ROOT_W-1:tfn_pkg::QUO_W]);
        quo_q[k] <= '0;
      end
    end else if (state_q == ST_RUN) begin
      nlo_q <= nlo_q << 1;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (degen_q) begin
        nrm[k] = '0;
      end else if (neg_q[k]) begin
        nrm[k] = -tfn_pkg::normal_t'(quo_q[k]);
      end else begin
        nrm[k] = tfn_pkg::normal_t'(quo_q[k]);
      end
    end
  end

  assign valid_o          = (state_q == ST_HOLD);
  assign res_o.normal_x   = nrm[0];
  assign res_o.normal_y   = nrm[1];
  assign res_o.normal_z   = nrm[2];
  assign res_o.degenerate = degen_q;

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && !degen_q) |->
      (quo_q[0] <= tfn_pkg::QUO_MAX && quo_q[1] <= tfn_pkg::QUO_MAX
       && quo_q[2] <= tfn_pkg::QUO_MAX))
    else $error("normal component exceeds unit length");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int ITEM_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int HOLD_AFTER   = 80;    // face normal requests issued before the hold-off
  localparam int DRAIN_CYCLES = 200;   // exceeds the worst face normal latency
  localparam int REPORT_LIMIT = 10;

  localparam tfn_pkg::coord_t EXTREME_COORDS [6] = '{-16'sd32768, -16'sd32767, -16'sd1,
                                                      16'sd0, 16'sd1, 16'sd32767};

  // One input transaction as the testbench builds it.
  typedef struct packed {
    logic            mode;
    tfn_pkg::idx_t   vertex_index;
    tfn_pkg::coord_t pos_x;
    tfn_pkg::coord_t pos_y;
    tfn_pkg::coord_t pos_z;
    tfn_pkg::idx_t   corner_a;
    tfn_pkg::idx_t   corner_b;
    tfn_pkg::idx_t   corner_c;
  } mesh_cmd_t;

  // Holds a private copy of the vertex store and the queue of normals still owed.
  class normal_scoreboard;
    tfn_pkg::vertex_t positions [tfn_pkg::VERTEX_DEPTH];
    tfn_pkg::result_t owed_normals [$];
    int      errors;
    int      writes_noted;
    int      normals_noted;
    int      normals_checked;
    int      degenerate_owed;

    function tfn_pkg::vertex_t fetch(tfn_pkg::idx_t idx);
      // An index past the store reads as the origin.
      if (int'(idx) < tfn_pkg::VERTEX_DEPTH) return positions[idx];
      return '0;
    endfunction

    // Face normal of corners A, B, C: cross product (C - A) x (B - A) scaled to Q1.14.
    function tfn_pkg::result_t face_normal(tfn_pkg::idx_t ia, tfn_pkg::idx_t ib,
                                           tfn_pkg::idx_t ic);
      tfn_pkg::vertex_t  pa, pb, pc;
      longint            ea [3];
      longint            eb [3];
      longint            cr [3];
      longint unsigned   mag [3];
      longint unsigned   quot [3];
      bit                neg [3];
      longint unsigned   peak, sum, root, trial;
      int                msb;
      tfn_pkg::result_t  r;
      pa = fetch(ia);
      pb = fetch(ib);
      pc = fetch(ic);
      ea[0] = longint'(pb.x) - longint'(pa.x);
      ea[1] = longint'(pb.y) - longint'(pa.y);
      ea[2] = longint'(pb.z) - longint'(pa.z);
      eb[0] = longint'(pc.x) - longint'(pa.x);
      eb[1] = longint'(pc.y) - longint'(pa.y);
      eb[2] = longint'(pc.z) - longint'(pa.z);
      cr[0] = eb[1] * ea[2] - eb[2] * ea[1];
      cr[1] = eb[2] * ea[0] - eb[0] * ea[2];
      cr[2] = eb[0] * ea[1] - eb[1] * ea[0];
      peak = 0;
      for (int k = 0; k < 3; k++) begin
        neg[k] = cr[k] < 0;
        mag[k] = neg[k] ? $unsigned(-cr[k]) : $unsigned(cr[k]);
        if (mag[k] > peak) peak = mag[k];
      end
      r = '0;
      if (peak == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      // Align the largest magnitude so that its top bit lands on bit NORM_W-1.
      msb = 0;
      for (int i = 0; i < 64; i++) if (peak[i]) msb = i;
      for (int k = 0; k < 3; k++) begin
        if (msb < tfn_pkg::NORM_W - 1) mag[k] = mag[k] << (tfn_pkg::NORM_W - 1 - msb);
        else if (msb > tfn_pkg::NORM_W - 1) mag[k] = mag[k] >> (msb - (tfn_pkg::NORM_W - 1));
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      // Integer square root, one result bit per step from the top.
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= sum) root = trial;
      end
      // mag * 2^14 / root, rounded half up, capped at one.
      for (int k = 0; k < 3; k++) begin
        quot[k] = ((mag[k] << 15) + root) / (root << 1);
        if (quot[k] > (64'd1 << 14)) quot[k] = 64'd1 << 14;
      end
      r.normal_x = tfn_pkg::normal_t'(neg[0] ? 64'd0 - quot[0] : quot[0]);
      r.normal_y = tfn_pkg::normal_t'(neg[1] ? 64'd0 - quot[1] : quot[1]);
      r.normal_z = tfn_pkg::normal_t'(neg[2] ? 64'd0 - quot[2] : quot[2]);
      return r;
    endfunction

    function void note_command(mesh_cmd_t cmd);
      tfn_pkg::result_t r;
      if (cmd.mode == tfn_pkg::MODE_WRITE) begin
        writes_noted++;
        if (int'(cmd.vertex_index) < tfn_pkg::VERTEX_DEPTH)
          positions[cmd.vertex_index] = '{cmd.pos_x, cmd.pos_y, cmd.pos_z};
      end else begin
        normals_noted++;
        r = face_normal(cmd.corner_a, cmd.corner_b, cmd.corner_c);
        if (r.degenerate) degenerate_owed++;
        owed_normals = {owed_normals, r};
      end
    endfunction

    function void check_normal(tfn_pkg::result_t got);
      tfn_pkg::result_t want;
      if (owed_normals.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] unexpected normal (%0d,%0d,%0d) degenerate=%0b", $time,
                   got.normal_x, got.normal_y, got.normal_z, got.degenerate);
        return;
      end
      want = owed_normals.pop_front();
      normals_checked++;
      if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
          got.normal_z !== want.normal_z || got.degenerate !== want.degenerate) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] mismatch: want (%0d,%0d,%0d) deg=%0b, got (%0d,%0d,%0d) deg=%0b",
                   $time, want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                   got.normal_x, got.normal_y, got.normal_z, got.degenerate);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tfn_in_if  cmd_if ();
  tfn_out_if nrm_if ();

  triangle_face_normal_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (nrm_if)
  );

  normal_scoreboard sb = new;

  // Written entries; face normals only ever name these, since the store holds
  // garbage until an entry is written.
  bit            written_mask [tfn_pkg::VERTEX_DEPTH];
  tfn_pkg::idx_t written_list [$];

  bit gaps_on  = 1'b1;   // cleared for stretches that run back to back
  bit hold_off = 1'b0;   // long receiver stall, owned by the pressure process
  int items_issued;
  int normals_issued;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int draw_gap();
    return gaps_on ? int'($urandom_range(0, 7)) : 0;
  endfunction

  // Coordinate flavors: full range, tiny, extremes, moderate.
  function automatic tfn_pkg::coord_t draw_coord(int flavor);
    case (flavor)
      0:       return tfn_pkg::coord_t'($urandom);
      1:       return tfn_pkg::coord_t'(span(-16, 16));
      2:       return EXTREME_COORDS[$urandom_range(0, 5)];
      default: return tfn_pkg::coord_t'(span(-2048, 2048));
    endcase
  endfunction

  function automatic tfn_pkg::idx_t pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // Offer one transaction after a random gap; hold valid and payload until taken.
  // With no gap, valid stays high straight into the next transaction.
  task automatic issue_command(input mesh_cmd_t cmd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.mode         <= cmd.mode;
    cmd_if.vertex_index <= cmd.vertex_index;
    cmd_if.pos_x        <= cmd.pos_x;
    cmd_if.pos_y        <= cmd.pos_y;
    cmd_if.pos_z        <= cmd.pos_z;
    cmd_if.corner_a     <= cmd.corner_a;
    cmd_if.corner_b     <= cmd.corner_b;
    cmd_if.corner_c     <= cmd.corner_c;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    sb.note_command(cmd);
    items_issued++;
    if (cmd.mode == tfn_pkg::MODE_NORMAL) normals_issued++;
  endtask

  // Write a vertex; the corner fields carry junk the block must ignore.
  task automatic put_vertex(input tfn_pkg::idx_t idx, input tfn_pkg::coord_t x,
                            input tfn_pkg::coord_t y, input tfn_pkg::coord_t z);
    mesh_cmd_t cmd;
    if (!written_mask[idx]) begin
      written_mask[idx] = 1'b1;
      written_list = {written_list, idx};
    end
    cmd = '{tfn_pkg::MODE_WRITE, idx, x, y, z, tfn_pkg::idx_t'($urandom),
            tfn_pkg::idx_t'($urandom), tfn_pkg::idx_t'($urandom)};
    issue_command(cmd);
  endtask

  // Request a face normal; the vertex fields carry junk the block must ignore.
  task automatic ask_normal(input tfn_pkg::idx_t a, input tfn_pkg::idx_t b,
                            input tfn_pkg::idx_t c);
    mesh_cmd_t cmd;
    cmd = '{tfn_pkg::MODE_NORMAL, tfn_pkg::idx_t'($urandom), tfn_pkg::coord_t'($urandom),
            tfn_pkg::coord_t'($urandom), tfn_pkg::coord_t'($urandom), a, b, c};
    issue_command(cmd);
  endtask

  task automatic run_directed();
    put_vertex(10'd0,    16'sd0,      16'sd0,      16'sd0);
    put_vertex(10'd1,    16'sd256,    16'sd0,      16'sd0);
    put_vertex(10'd2,    16'sd0,      16'sd256,    16'sd0);
    put_vertex(10'd1023, 16'sd32767, -16'sd32768,  16'sd32767);
    put_vertex(10'd3,   -16'sd32768,  16'sd32767, -16'sd32768);
    put_vertex(10'd4,    16'sd1,      16'sd1,      16'sd1);
    put_vertex(10'd5,    16'sd2,      16'sd2,      16'sd2);
    put_vertex(10'd6,    16'sd1,      16'sd0,      16'sd0);
    put_vertex(10'd7,    16'sd0,      16'sd1,      16'sd0);
    put_vertex(10'd8,    16'sd0,      16'sd0,      16'sd1);
    put_vertex(10'd9,    16'sd24000,  16'sd0,      16'sd0);
    put_vertex(10'd512,  16'sd0,      16'sd24000,  16'sd0);
    ask_normal(10'd0, 10'd1, 10'd2);         // unit axes, normal along -z
    ask_normal(10'd0, 10'd2, 10'd1);         // corner order swapped, +z
    ask_normal(10'd0, 10'd0, 10'd0);         // all corners equal: degenerate
    ask_normal(10'd0, 10'd4, 10'd5);         // collinear corners: degenerate
    ask_normal(10'd1023, 10'd3, 10'd0);      // largest edges, shift left
    ask_normal(10'd3, 10'd1023, 10'd4);
    ask_normal(10'd0, 10'd6, 10'd7);         // cross product of one, full shift left
    ask_normal(10'd6, 10'd7, 10'd8);         // equal components
    ask_normal(10'd0, 10'd9, 10'd512);       // magnitude already aligned, no shift
    ask_normal(10'd1023, 10'd1023, 10'd3);   // A equals B: degenerate
    put_vertex(10'd1, -16'sd256, 16'sd0, 16'sd0);
    ask_normal(10'd0, 10'd1, 10'd2);         // overwritten corner must be seen
  endtask

  task automatic run_random();
    int              pick, flavor;
    tfn_pkg::idx_t   ia, ib, ic;
    tfn_pkg::coord_t bx, by, bz, dx, dy, dz;
    while (items_issued < ITEM_TARGET) begin
      // Every third stretch of 250 transactions runs with no gaps on either side.
      gaps_on <= ((items_issued / 250) % 3) != 1;
      pick = int'($urandom_range(0, 99));
      if (pick < 38) begin
        // Lone write, sometimes overwriting a live entry.
        ia = ($urandom_range(0, 4) == 0) ? pick_written() : tfn_pkg::idx_t'($urandom);
        flavor = int'($urandom_range(0, 3));
        put_vertex(ia, draw_coord(flavor), draw_coord(flavor), draw_coord(flavor));
      end else if (pick < 78) begin
        // Normal over live entries, now and then with a repeated corner.
        ia = pick_written();
        ib = pick_written();
        ic = pick_written();
        case ($urandom_range(0, 11))
          0:       ib = ia;
          1:       ic = ia;
          2:       ic = ib;
          default: ;
        endcase
        ask_normal(ia, ib, ic);
      end else if (pick < 95) begin
        // Fresh triangle of one flavor, then its normal in either winding.
        flavor = int'($urandom_range(0, 3));
        ia = tfn_pkg::idx_t'($urandom);
        ib = tfn_pkg::idx_t'($urandom);
        ic = tfn_pkg::idx_t'($urandom);
        put_vertex(ia, draw_coord(flavor), draw_coord(flavor), draw_coord(flavor));
        put_vertex(ib, draw_coord(flavor), draw_coord(flavor), draw_coord(flavor));
        put_vertex(ic, draw_coord(flavor), draw_coord(flavor), draw_coord(flavor));
        if ($urandom_range(0, 1)) ask_normal(ia, ib, ic);
        else ask_normal(ic, ib, ia);
      end else begin
        // Three points on a line: the normal must come out degenerate.
        bx = tfn_pkg::coord_t'(span(-10000, 10000));
        by = tfn_pkg::coord_t'(span(-10000, 10000));
        bz = tfn_pkg::coord_t'(span(-10000, 10000));
        dx = tfn_pkg::coord_t'(span(-1000, 1000));
        dy = tfn_pkg::coord_t'(span(-1000, 1000));
        dz = tfn_pkg::coord_t'(span(-1000, 1000));
        ia = tfn_pkg::idx_t'($urandom);
        ib = tfn_pkg::idx_t'($urandom);
        ic = tfn_pkg::idx_t'($urandom);
        put_vertex(ia, bx, by, bz);
        put_vertex(ib, bx + dx, by + dy, bz + dz);
        put_vertex(ic, tfn_pkg::coord_t'(bx + 2 * dx), tfn_pkg::coord_t'(by + 2 * dy),
                   tfn_pkg::coord_t'(bz + 2 * dz));
        ask_normal(ia, ib, ic);
      end
    end
  endtask

  // Receiver: once a normal is offered, wait the drawn stall, then take it.
  initial begin
    int               stall_left;
    tfn_pkg::result_t got;
    stall_left = 0;
    nrm_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (nrm_if.valid === 1'b1 && nrm_if.ready === 1'b1) begin
        got.normal_x   = nrm_if.normal_x;
        got.normal_y   = nrm_if.normal_y;
        got.normal_z   = nrm_if.normal_z;
        got.degenerate = nrm_if.degenerate;
        sb.check_normal(got);
        stall_left = draw_gap();
      end else if (nrm_if.valid === 1'b1 && stall_left > 0) begin
        stall_left--;
      end
      nrm_if.ready <= rst_ni && !hold_off && stall_left == 0;
    end
  end

  // Pressure: hold off the receiver for a long stretch while requests keep coming,
  // so the output register and divider fill and the input stalls.
  initial begin
    while (normals_issued < HOLD_AFTER) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    cmd_if.valid        <= 1'b0;
    cmd_if.mode         <= tfn_pkg::MODE_WRITE;
    cmd_if.vertex_index <= '0;
    cmd_if.pos_x        <= '0;
    cmd_if.pos_y        <= '0;
    cmd_if.pos_z        <= '0;
    cmd_if.corner_a     <= '0;
    cmd_if.corner_b     <= '0;
    cmd_if.corner_c     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    cmd_if.valid <= 1'b0;

    // Drain: wait for every owed normal, then let a trailing write settle.
    while (sb.owed_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.owed_normals.size() != 0) begin
      sb.errors += sb.owed_normals.size();
      $display("%0d face normals never arrived", sb.owed_normals.size());
    end
    $display("Covered %0d vertex writes and %0d face normal requests; %0d normals checked,",
             sb.writes_noted, sb.normals_noted, sb.normals_checked);
    $display("  %0d degenerate, with random gaps, gap-free stretches and a %0d-cycle stall.",
             sb.degenerate_owed, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tfn_pkg.sv
design/tfn_if.sv
design/tfn_ram.sv
design/tfn_cross.sv
design/tfn_root.sv
design/tfn_div.sv
design/triangle_face_normal_core.sv
dv/tb_top.sv
